// ----- src/aprm_pkg.sv -----
package aprm_pkg;

	localparam int IMG_DIM_DEF    = 1000;
	localparam int RING_INNER_DEF = 4;
	localparam int RING_OUTER_DEF = 5;
	localparam int MAX_RESULTS    = 36;

	localparam int COEF_W   = 32;
	localparam int SRC_W    = 18;
	localparam int PROD_W   = COEF_W + SRC_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int FRAC_BITS = 28;
	localparam int OFF_SHIFT = 12;
	localparam int CRD_W    = ACC_W - FRAC_BITS;
	localparam int PIX_W    = 10;
	localparam int OFF_W    = 4;
	localparam int CFG_IDX_W = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

	typedef struct packed {
		logic [CRD_W-1:0] cx;
		logic [CRD_W-1:0] cy;
	} centre_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} back_state_t;

	function automatic bit ring_hit(int inner, int outer, int dx, int dy);
		int d2;
		d2 = dx * dx + dy * dy;
		return (d2 >= inner * inner) && (d2 <= outer * outer);
	endfunction

	function automatic int ring_count(int inner, int outer);
		int n;
		int w;
		n = 0;
		w = outer + 1;
		for (int dx = -w; dx <= w; dx++) begin
			for (int dy = -w; dy <= w; dy++) begin
				if (ring_hit(inner, outer, dx, dy))
					n++;
			end
		end
		return n;
	endfunction

	// k-th ring offset in scan order; sel 0 gives dx, 1 gives dy
	function automatic int ring_off(int inner, int outer, int k, bit sel);
		int n;
		int w;
		int r;
		n = 0;
		w = outer + 1;
		r = 0;
		for (int dx = -w; dx <= w; dx++) begin
			for (int dy = -w; dy <= w; dy++) begin
				if (ring_hit(inner, outer, dx, dy)) begin
					if (n == k)
						r = sel ? dy : dx;
					n++;
				end
			end
		end
		return r;
	endfunction

endpackage

// ----- src/aprm_front.sv -----
module aprm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [aprm_pkg::SRC_W-1:0]   src_x,
	input  logic signed [aprm_pkg::SRC_W-1:0]   src_y,
	input  logic                                cfg_valid,
	input  logic [aprm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aprm_pkg::COEF_W-1:0]         cfg_data,
	input  logic [aprm_pkg::QCNT_W-1:0]         q_count,
	output logic                                push,
	output aprm_pkg::centre_t                   push_data
);

	localparam int ACC_W = aprm_pkg::ACC_W;
	localparam int CRD_W = aprm_pkg::CRD_W;
	localparam int FB    = aprm_pkg::FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FB - 1);

	logic signed [aprm_pkg::COEF_W-1:0] coef_xx_q, coef_xy_q, offset_x_q;
	logic signed [aprm_pkg::COEF_W-1:0] coef_yx_q, coef_yy_q, offset_y_q;

	logic v_s1, v_s2, v_s3;
	logic signed [aprm_pkg::PROD_W-1:0] p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1;
	logic signed [aprm_pkg::COEF_W-1:0] off_x_s1, off_y_s1;
	logic signed [ACC_W-1:0] acc_x_s2, acc_y_s2;
	aprm_pkg::centre_t centre_s3;

	logic [aprm_pkg::QCNT_W:0] used;
	logic corr_x, corr_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q  <= '0;
			coef_xy_q  <= '0;
			offset_x_q <= '0;
			coef_yx_q  <= '0;
			coef_yy_q  <= '0;
			offset_y_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				aprm_pkg::REG_COEF_XX:  coef_xx_q  <= cfg_data;
				aprm_pkg::REG_COEF_XY:  coef_xy_q  <= cfg_data;
				aprm_pkg::REG_OFFSET_X: offset_x_q <= cfg_data;
				aprm_pkg::REG_COEF_YX:  coef_yx_q  <= cfg_data;
				aprm_pkg::REG_COEF_YY:  coef_yy_q  <= cfg_data;
				aprm_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// credit: queue fill plus beats in flight must leave a free slot
	assign used = (aprm_pkg::QCNT_W + 1)'(q_count) + (aprm_pkg::QCNT_W + 1)'(v_s1)
		+ (aprm_pkg::QCNT_W + 1)'(v_s2) + (aprm_pkg::QCNT_W + 1)'(v_s3);
	assign in_stall = used >= (aprm_pkg::QCNT_W + 1)'(aprm_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid && !in_stall;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign corr_x = acc_x_s2[ACC_W-1] && (|acc_x_s2[FB-1:0]);
	assign corr_y = acc_y_s2[ACC_W-1] && (|acc_y_s2[FB-1:0]);

	always_ff @(posedge clk) begin
		p_xx_s1  <= coef_xx_q * src_x;
		p_xy_s1  <= coef_xy_q * src_y;
		p_yx_s1  <= coef_yx_q * src_x;
		p_yy_s1  <= coef_yy_q * src_y;
		off_x_s1 <= offset_x_q;
		off_y_s1 <= offset_y_q;
		acc_x_s2 <= ACC_W'(p_xx_s1) + ACC_W'(p_xy_s1)
			+ (ACC_W'(off_x_s1) <<< aprm_pkg::OFF_SHIFT) + HALF;
		acc_y_s2 <= ACC_W'(p_yx_s1) + ACC_W'(p_yy_s1)
			+ (ACC_W'(off_y_s1) <<< aprm_pkg::OFF_SHIFT) + HALF;
		// floor, then one up for a negative value with a fraction: truncation toward zero
		centre_s3.cx <= acc_x_s2[ACC_W-1 -: CRD_W] + CRD_W'(corr_x);
		centre_s3.cy <= acc_y_s2[ACC_W-1 -: CRD_W] + CRD_W'(corr_y);
	end

	assign push      = v_s3;
	assign push_data = centre_s3;

endmodule

// ----- src/aprm_queue.sv -----
module aprm_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  aprm_pkg::centre_t             push_data,
	input  logic                          pop,
	output logic                          q_valid,
	output aprm_pkg::centre_t             q_data,
	output logic [aprm_pkg::QCNT_W-1:0]   q_count
);

	aprm_pkg::centre_t entry_q [aprm_pkg::QUEUE_DEPTH];
	logic [aprm_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [aprm_pkg::QCNT_W-1:0] count_q;
	logic do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + aprm_pkg::QCNT_W'(push) - aprm_pkg::QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	assign q_valid = count_q != '0;
	assign q_data  = entry_q[rd_ptr_q];
	assign q_count = count_q;

endmodule

// ----- src/aprm_back.sv -----
module aprm_back #(
	parameter int IMG_DIM    = aprm_pkg::IMG_DIM_DEF,
	parameter int RING_INNER = aprm_pkg::RING_INNER_DEF,
	parameter int RING_OUTER = aprm_pkg::RING_OUTER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  aprm_pkg::centre_t             q_data,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [aprm_pkg::PIX_W-1:0]    pixel_x,
	output logic [aprm_pkg::PIX_W-1:0]    pixel_y,
	output logic                          pixel_valid,
	output logic                          last
);

	localparam int CRD_W    = aprm_pkg::CRD_W;
	localparam int PIX_W    = aprm_pkg::PIX_W;
	localparam int OFF_W    = aprm_pkg::OFF_W;
	localparam int TAB_LEN  = aprm_pkg::ring_count(RING_INNER, RING_OUTER);
	localparam int TAB_SIZE = (TAB_LEN > 0) ? TAB_LEN : 1;
	localparam int K_W      = (TAB_SIZE > 1) ? $clog2(TAB_SIZE) : 1;
	localparam int N_W      = $clog2(aprm_pkg::MAX_RESULTS + 1);

	logic signed [OFF_W-1:0] tab_dx [TAB_SIZE];
	logic signed [OFF_W-1:0] tab_dy [TAB_SIZE];

	for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
		localparam int DXV = aprm_pkg::ring_off(RING_INNER, RING_OUTER, g, 1'b0);
		localparam int DYV = aprm_pkg::ring_off(RING_INNER, RING_OUTER, g, 1'b1);
		assign tab_dx[g] = OFF_W'(DXV);
		assign tab_dy[g] = OFF_W'(DYV);
	end

	aprm_pkg::back_state_t state_q, state_d;
	logic [K_W-1:0]   k_q, k_d;
	logic [N_W-1:0]   n_q, n_d;
	logic             pend_v_q, pend_v_d;
	logic [PIX_W-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
	logic [CRD_W-1:0] cx_q, cy_q;

	logic             out_valid_q, pixel_valid_q, last_q;
	logic [PIX_W-1:0] pixel_x_q, pixel_y_q;

	logic             ospace, load, hit;
	logic             push, push_pv, push_last;
	logic [PIX_W-1:0] push_x, push_y;
	logic [CRD_W-1:0] px, py;

	assign ospace = !out_valid_q || !out_stall;
	assign px  = cx_q + CRD_W'(tab_dx[k_q]);
	assign py  = cy_q + CRD_W'(tab_dy[k_q]);
	assign hit = !px[CRD_W-1] && (px < CRD_W'(IMG_DIM))
		&& !py[CRD_W-1] && (py < CRD_W'(IMG_DIM));

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		n_d       = n_q;
		pend_v_d  = pend_v_q;
		pend_x_d  = pend_x_q;
		pend_y_d  = pend_y_q;
		pop       = 1'b0;
		load      = 1'b0;
		push      = 1'b0;
		push_x    = '0;
		push_y    = '0;
		push_pv   = 1'b0;
		push_last = 1'b0;
		case (state_q)
			aprm_pkg::BK_IDLE: begin
				if (q_valid) begin
					pop  = 1'b1;
					load = 1'b1;
				end
			end
			aprm_pkg::BK_SCAN: begin
				if (ospace) begin
					if (hit) begin
						// a held pixel goes out once a later one proves it is not last
						if (pend_v_q) begin
							push    = 1'b1;
							push_x  = pend_x_q;
							push_y  = pend_y_q;
							push_pv = 1'b1;
						end
						pend_v_d = 1'b1;
						pend_x_d = px[PIX_W-1:0];
						pend_y_d = py[PIX_W-1:0];
						n_d      = n_q + 1'b1;
					end
					if (k_q == K_W'(TAB_SIZE - 1)
						|| (hit && n_q == N_W'(aprm_pkg::MAX_RESULTS - 1)))
						state_d = aprm_pkg::BK_FLUSH;
					else
						k_d = k_q + 1'b1;
				end
			end
			aprm_pkg::BK_FLUSH: begin
				if (ospace) begin
					push      = 1'b1;
					push_x    = pend_v_q ? pend_x_q : '0;
					push_y    = pend_v_q ? pend_y_q : '0;
					push_pv   = pend_v_q;
					push_last = 1'b1;
					state_d   = aprm_pkg::BK_IDLE;
					if (q_valid) begin
						pop  = 1'b1;
						load = 1'b1;
					end
				end
			end
			default: state_d = aprm_pkg::BK_IDLE;
		endcase
		if (load) begin
			state_d  = (TAB_LEN == 0) ? aprm_pkg::BK_FLUSH : aprm_pkg::BK_SCAN;
			k_d      = '0;
			n_d      = '0;
			pend_v_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aprm_pkg::BK_IDLE;
			k_q         <= '0;
			n_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			k_q      <= k_d;
			n_q      <= n_d;
			pend_v_q <= pend_v_d;
			if (push)
				out_valid_q <= 1'b1;
			else if (ospace)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pend_x_q <= pend_x_d;
		pend_y_q <= pend_y_d;
		if (load) begin
			cx_q <= q_data.cx;
			cy_q <= q_data.cy;
		end
		if (push) begin
			pixel_x_q     <= push_x;
			pixel_y_q     <= push_y;
			pixel_valid_q <= push_pv;
			last_q        <= push_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_valid = pixel_valid_q;
	assign last        = last_q;

endmodule

// ----- src/affine_point_ring_marker.sv -----
// Path: a point passes through the 3-stage mapping pipeline, the queue, the ring scan and
// the output register before its first beat is offered.
// The ring scan steps one offset a cycle while the output is not stalled and scans one
// point at a time; the 4-deep queue hides the pipeline.
// Reset: arst_n clears config registers, queue and scan state at once; no clearing pass.
module affine_point_ring_marker #(
	parameter int IMG_DIM    = aprm_pkg::IMG_DIM_DEF,
	parameter int RING_INNER = aprm_pkg::RING_INNER_DEF,
	parameter int RING_OUTER = aprm_pkg::RING_OUTER_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [aprm_pkg::SRC_W-1:0]   src_x,
	input  logic signed [aprm_pkg::SRC_W-1:0]   src_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [aprm_pkg::PIX_W-1:0]          pixel_x,
	output logic [aprm_pkg::PIX_W-1:0]          pixel_y,
	output logic                                pixel_valid,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [aprm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aprm_pkg::COEF_W-1:0]         cfg_data
);

	logic                        push, pop, q_valid;
	aprm_pkg::centre_t           push_data, q_data;
	logic [aprm_pkg::QCNT_W-1:0] q_count;

	assign cfg_ready = 1'b1;

	aprm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.src_x     (src_x),
		.src_y     (src_y),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	aprm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_count   (q_count)
	);

	aprm_back #(
		.IMG_DIM    (IMG_DIM),
		.RING_INNER (RING_INNER),
		.RING_OUTER (RING_OUTER)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_valid (pixel_valid),
		.last        (last)
	);

endmodule

// ----- src/aprm_checker.sv -----
module aprm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic signed [aprm_pkg::SRC_W-1:0]   src_x,
	input logic signed [aprm_pkg::SRC_W-1:0]   src_y,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [aprm_pkg::PIX_W-1:0]          pixel_x,
	input logic [aprm_pkg::PIX_W-1:0]          pixel_y,
	input logic                                pixel_valid,
	input logic                                last,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [aprm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [aprm_pkg::COEF_W-1:0]         cfg_data
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_valid) && $stable(last))
		else $error("stalled result beat changed");

	// a beat with no valid pixel is the closing beat
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> last)
		else $error("invalid pixel beat not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0)
		else $error("invalid pixel beat carries a coordinate");

	a_no_out_in_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result beat offered during reset");

endmodule

bind affine_point_ring_marker aprm_checker u_aprm_checker (.*);
